@@ rtl/image_rotation_address_generator_assert.svh @@
// ----------------------------------------------------------------------------
// image_rotation_address_generator_assert.svh
// Assertion helpers for the image rotation address generator.
// Users must have i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATION_ADDRESS_GENERATOR_ASSERT_SVH
`define IMAGE_ROTATION_ADDRESS_GENERATOR_ASSERT_SVH

// Clocked property, ignored while reset is held
`define IMROT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication built on the one above
`define IMROT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    `IMROT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/imrot_pkg.sv @@
// ----------------------------------------------------------------------------
// imrot_pkg
// Shared types and constants of the image rotation address generator.
// ----------------------------------------------------------------------------
package imrot_pkg;

    // Coefficient format: signed fixed point, fixed 16-bit storage
    localparam int COEF_W    = 16;
    localparam int QT_W      = 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH      = 3'd0,
        CFG_SRC_HEIGHT     = 3'd1,
        CFG_DST_WIDTH      = 3'd2,
        CFG_DST_HEIGHT     = 3'd3,
        CFG_COS_COEF       = 3'd4,
        CFG_SIN_COEF       = 3'd5,
        CFG_QUARTER_TURNS  = 3'd6,
        CFG_ARBITRARY_MODE = 3'd7
    } t_cfg_idx;

    // Quarter-turn counts
    localparam logic [QT_W-1:0] QT_NONE = 2'd0;
    localparam logic [QT_W-1:0] QT_ONE  = 2'd1;
    localparam logic [QT_W-1:0] QT_TWO  = 2'd2;

    // Mapping mode settings handed to the coordinate mapper
    typedef struct packed {
        logic [COEF_W-1:0] cos_coef;
        logic [COEF_W-1:0] sin_coef;
        logic [QT_W-1:0]   quarter_turns;
        logic              arbitrary_mode;
    } t_mode_cfg;

endpackage

@@ rtl/image_rotation_address_generator.sv @@
// ----------------------------------------------------------------------------
// image_rotation_address_generator
// Nearest-neighbor inverse mapping for image rotation: destination pixel in,
// source row, column, linear address and inside flag out.
//
//   Channel   Direction  Handshake              Payload
//   -------   ---------  ---------------------  ---------------------------------
//   pixel in  in         i_valid / o_stall      i_out_row, i_out_col
//   result    out        o_valid / i_stall      o_src_row, o_src_col,
//                                               o_src_address, o_inside_res
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per clock sustained while i_stall is low (5 mapper stages: center,
// multiply, sum, truncate, re-center/bounds; 2 address stages: multiply, add).
// Reset clears all stage valids and loads the register defaults.
// Empty stages close up under i_stall, so o_stall rises only when every
// stage holds a request and the output is stalled.
// ----------------------------------------------------------------------------
module image_rotation_address_generator
    import imrot_pkg::*;
#(
    parameter int MAX_DIM        = 8192,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // pixel requests
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [$clog2(MAX_DIM)-1:0] i_out_row,
    input  logic [$clog2(MAX_DIM)-1:0] i_out_col,
    // results
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [$clog2(MAX_DIM)-1:0] o_src_row,
    output logic [$clog2(MAX_DIM)-1:0] o_src_col,
    output logic [2*$clog2(MAX_DIM)-1:0] o_src_address,
    output logic                       o_inside_res,
    // register writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [(($clog2(MAX_DIM) > COEF_W) ? $clog2(MAX_DIM) : COEF_W)-1:0] i_cfg_data
);

    `include "image_rotation_address_generator_assert.svh"

    localparam int DW = $clog2(MAX_DIM);

    // Configuration registers
    logic [DW-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    t_mode_cfg     r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width          <= DW'(1);
            r_src_height         <= DW'(1);
            r_dst_width          <= DW'(1);
            r_dst_height         <= DW'(1);
            r_mode.cos_coef       <= COEF_W'(1 << COEF_FRAC_BITS);
            r_mode.sin_coef       <= '0;
            r_mode.quarter_turns  <= QT_NONE;
            r_mode.arbitrary_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:      r_src_width          <= i_cfg_data[DW-1:0];
                CFG_SRC_HEIGHT:     r_src_height         <= i_cfg_data[DW-1:0];
                CFG_DST_WIDTH:      r_dst_width          <= i_cfg_data[DW-1:0];
                CFG_DST_HEIGHT:     r_dst_height         <= i_cfg_data[DW-1:0];
                CFG_COS_COEF:       r_mode.cos_coef       <= i_cfg_data[COEF_W-1:0];
                CFG_SIN_COEF:       r_mode.sin_coef       <= i_cfg_data[COEF_W-1:0];
                CFG_QUARTER_TURNS:  r_mode.quarter_turns  <= i_cfg_data[QT_W-1:0];
                CFG_ARBITRARY_MODE: r_mode.arbitrary_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Coordinate mapper
    logic          map_ready, map_valid, addr_ready;
    logic [DW-1:0] map_row, map_col;
    logic          map_inside;

    imrot_map #(
        .DW             (DW),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (map_ready),
        .i_out_row    (i_out_row),
        .i_out_col    (i_out_col),
        .i_src_width  (r_src_width),
        .i_src_height (r_src_height),
        .i_dst_width  (r_dst_width),
        .i_dst_height (r_dst_height),
        .i_mode       (r_mode),
        .o_valid      (map_valid),
        .i_ready      (addr_ready),
        .o_row        (map_row),
        .o_col        (map_col),
        .o_inside     (map_inside)
    );

    // Address unit and output register
    imrot_addr #(
        .DW (DW)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (map_valid),
        .o_ready       (addr_ready),
        .i_row         (map_row),
        .i_col         (map_col),
        .i_inside      (map_inside),
        .i_src_width   (r_src_width),
        .o_valid       (o_valid),
        .i_ready       (!i_stall),
        .o_src_row     (o_src_row),
        .o_src_col     (o_src_col),
        .o_src_address (o_src_address),
        .o_inside_res  (o_inside_res)
    );

    assign o_stall = !map_ready;

    // Checks
    `IMROT_ASSERT_IMPLIES(a_outside_zero, o_valid && !o_inside_res,
        (o_src_row == '0) && (o_src_col == '0) && (o_src_address == '0),
        "outside result carries nonzero fields")
    `IMROT_ASSERT_IMPLIES(a_stall_only_full, o_stall, o_valid && i_stall,
        "input stalled while output is free")
    `IMROT_ASSERT(a_addr_match,
        o_valid |-> (o_src_address == ({{DW{1'b0}}, o_src_row} * {{DW{1'b0}}, r_src_width}
                                       + {{DW{1'b0}}, o_src_col})),
        "address does not match row and column")

endmodule

@@ rtl/imrot_map.sv @@
// ----------------------------------------------------------------------------
// imrot_map
// Five-stage coordinate mapper: destination pixel to source row/column with
// bounds test. Quarter-turn result rides alongside the rotation datapath.
// ----------------------------------------------------------------------------
module imrot_map
    import imrot_pkg::*;
#(
    parameter int DW             = 13,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request in
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [DW-1:0]         i_out_row,
    input  logic [DW-1:0]         i_out_col,
    // settings
    input  logic [DW-1:0]         i_src_width,
    input  logic [DW-1:0]         i_src_height,
    input  logic [DW-1:0]         i_dst_width,
    input  logic [DW-1:0]         i_dst_height,
    input  t_mode_cfg             i_mode,
    // request out
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DW-1:0]         o_row,
    output logic [DW-1:0]         o_col,
    output logic                  o_inside
);

    localparam int NSTG = 5;
    localparam int QW   = DW + 2;           // quarter-turn coordinate, signed
    localparam int PW   = DW + 1 + COEF_W;  // one product
    localparam int SW   = PW + 2;           // re-centered coordinate
    localparam int F    = COEF_FRAC_BITS;

    // Stage valids and enables; a stage loads when empty or draining
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   stg_en;

    always_comb begin
        stg_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign n_vld   = {r_vld[NSTG-2:0], i_valid};
    assign o_ready = stg_en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Quarter-turn coordinates travel down a delay line
    logic signed [QW-1:0] r_qrow [NSTG-1];
    logic signed [QW-1:0] r_qcol [NSTG-1];

    // Stage 0: center on destination, quarter-turn mapping
    logic signed [DW:0]   n_ox, n_oy, r_ox, r_oy;
    logic signed [QW-1:0] n_qrow, n_qcol;
    logic        [QW-1:0] ext_h_m1, ext_w_m1, ext_r, ext_c;

    assign n_ox = {1'b0, i_out_col} - {2'b00, i_dst_width[DW-1:1]};
    assign n_oy = {1'b0, i_out_row} - {2'b00, i_dst_height[DW-1:1]};

    assign ext_h_m1 = {2'b00, i_src_height} - {{(QW-1){1'b0}}, 1'b1};
    assign ext_w_m1 = {2'b00, i_src_width} - {{(QW-1){1'b0}}, 1'b1};
    assign ext_r    = {2'b00, i_out_row};
    assign ext_c    = {2'b00, i_out_col};

    always_comb begin
        case (i_mode.quarter_turns)
            QT_NONE: begin
                n_qrow = ext_r;
                n_qcol = ext_c;
            end
            QT_ONE: begin
                n_qrow = ext_h_m1 - ext_c;
                n_qcol = ext_r;
            end
            QT_TWO: begin
                n_qrow = ext_h_m1 - ext_r;
                n_qcol = ext_w_m1 - ext_c;
            end
            default: begin
                n_qrow = ext_c;
                n_qcol = ext_w_m1 - ext_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_ox      <= n_ox;
            r_oy      <= n_oy;
            r_qrow[0] <= n_qrow;
            r_qcol[0] <= n_qcol;
        end
    end

    // Stage 1: four products
    logic signed [PW-1:0] n_p_xc, n_p_ys, n_p_xs, n_p_yc;
    logic signed [PW-1:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;

    assign n_p_xc = r_ox * $signed(i_mode.cos_coef);
    assign n_p_ys = r_oy * $signed(i_mode.sin_coef);
    assign n_p_xs = r_ox * $signed(i_mode.sin_coef);
    assign n_p_yc = r_oy * $signed(i_mode.cos_coef);

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_p_xc    <= n_p_xc;
            r_p_ys    <= n_p_ys;
            r_p_xs    <= n_p_xs;
            r_p_yc    <= n_p_yc;
            r_qrow[1] <= r_qrow[0];
            r_qcol[1] <= r_qcol[0];
        end
    end

    // Stage 2: rotated sums, exact
    logic signed [PW:0] n_sum_x, n_sum_y, r_sum_x, r_sum_y;

    assign n_sum_x = {r_p_xc[PW-1], r_p_xc} - {r_p_ys[PW-1], r_p_ys};
    assign n_sum_y = {r_p_xs[PW-1], r_p_xs} + {r_p_yc[PW-1], r_p_yc};

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_sum_x   <= n_sum_x;
            r_sum_y   <= n_sum_y;
            r_qrow[2] <= r_qrow[1];
            r_qcol[2] <= r_qcol[1];
        end
    end

    // Stage 3: drop fraction, rounding toward zero (bias negatives first)
    logic signed [PW:0] bias_x, bias_y;
    logic signed [PW:0] n_tx, n_ty, r_tx, r_ty;

    assign bias_x = {{(PW+1-F){1'b0}}, {F{r_sum_x[PW]}}};
    assign bias_y = {{(PW+1-F){1'b0}}, {F{r_sum_y[PW]}}};
    assign n_tx   = (r_sum_x + bias_x) >>> F;
    assign n_ty   = (r_sum_y + bias_y) >>> F;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_tx      <= n_tx;
            r_ty      <= n_ty;
            r_qrow[3] <= r_qrow[2];
            r_qcol[3] <= r_qcol[2];
        end
    end

    // Stage 4: re-center on source, pick mode, bounds test
    logic signed [SW-1:0] arb_row, arb_col, sel_row, sel_col;
    logic                 n_inside;
    logic [DW-1:0]        r_row, r_col;
    logic                 r_inside;

    assign arb_row = {r_ty[PW], r_ty} + {{(SW-DW+1){1'b0}}, i_src_height[DW-1:1]};
    assign arb_col = {r_tx[PW], r_tx} + {{(SW-DW+1){1'b0}}, i_src_width[DW-1:1]};

    always_comb begin
        if (i_mode.arbitrary_mode) begin
            sel_row = arb_row;
            sel_col = arb_col;
        end else begin
            sel_row = {{(SW-QW){r_qrow[3][QW-1]}}, r_qrow[3]};
            sel_col = {{(SW-QW){r_qcol[3][QW-1]}}, r_qcol[3]};
        end
    end

    assign n_inside = !sel_row[SW-1] && (sel_row < {{(SW-DW){1'b0}}, i_src_height})
                   && !sel_col[SW-1] && (sel_col < {{(SW-DW){1'b0}}, i_src_width});

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_row    <= n_inside ? sel_row[DW-1:0] : '0;
            r_col    <= n_inside ? sel_col[DW-1:0] : '0;
            r_inside <= n_inside;
        end
    end

    assign o_row    = r_row;
    assign o_col    = r_col;
    assign o_inside = r_inside;

endmodule

@@ rtl/imrot_addr.sv @@
// ----------------------------------------------------------------------------
// imrot_addr
// Two-stage linear address unit: row times source width, then plus column.
// The last stage is the block's output register.
// ----------------------------------------------------------------------------
module imrot_addr
    import imrot_pkg::*;
#(
    parameter int DW = 13
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request in
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [DW-1:0]   i_row,
    input  logic [DW-1:0]   i_col,
    input  logic            i_inside,
    input  logic [DW-1:0]   i_src_width,
    // request out
    output logic            o_valid,
    input  logic            i_ready,
    output logic [DW-1:0]   o_src_row,
    output logic [DW-1:0]   o_src_col,
    output logic [2*DW-1:0] o_src_address,
    output logic            o_inside_res
);

    localparam int NSTG = 2;
    localparam int AW   = 2 * DW;

    // Stage valids and enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   stg_en;

    always_comb begin
        stg_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign n_vld   = {r_vld[NSTG-2:0], i_valid};
    assign o_ready = stg_en[0];
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // Stage 0: row * width (row is zero for outside pixels)
    logic [AW-1:0] n_prod, r_prod;
    logic [DW-1:0] r_row0, r_col0;
    logic          r_in0;

    assign n_prod = {{DW{1'b0}}, i_row} * {{DW{1'b0}}, i_src_width};

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_prod <= n_prod;
            r_row0 <= i_row;
            r_col0 <= i_col;
            r_in0  <= i_inside;
        end
    end

    // Stage 1: add column, output register
    logic [AW-1:0] r_addr;
    logic [DW-1:0] r_row1, r_col1;
    logic          r_in1;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_addr <= r_prod + {{DW{1'b0}}, r_col0};
            r_row1 <= r_row0;
            r_col1 <= r_col0;
            r_in1  <= r_in0;
        end
    end

    assign o_src_row     = r_row1;
    assign o_src_col     = r_col1;
    assign o_src_address = r_addr;
    assign o_inside_res  = r_in1;

endmodule
